[hw/rtl/b3sh_pkg.sv]
// ============================================================================
// b3sh_pkg
// Shared types and constants for the BLAKE3 stream hasher.
// ============================================================================
`default_nettype none

package b3sh_pkg;

    localparam logic [31:0] IV0 = 32'h6A09E667;
    localparam logic [31:0] IV1 = 32'hBB67AE85;
    localparam logic [31:0] IV2 = 32'h3C6EF372;
    localparam logic [31:0] IV3 = 32'hA54FF53A;
    localparam logic [31:0] IV4 = 32'h510E527F;
    localparam logic [31:0] IV5 = 32'h9B05688C;
    localparam logic [31:0] IV6 = 32'h1F83D9AB;
    localparam logic [31:0] IV7 = 32'h5BE0CD19;

    localparam logic [255:0] IV_ALL = {IV7, IV6, IV5, IV4, IV3, IV2, IV1, IV0};

    localparam logic [31:0] FL_START  = 32'd1;
    localparam logic [31:0] FL_END    = 32'd2;
    localparam logic [31:0] FL_PARENT = 32'd4;
    localparam logic [31:0] FL_ROOT   = 32'd8;

    localparam logic [53:0] CHUNK_INDEX_MAX = {54{1'b1}};
    localparam int          ROUNDS          = 7;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;

    // Compression request from the sequencer to the round unit.
    typedef struct packed {
        logic [255:0] cv;
        logic [511:0] msg;
        logic [63:0]  ctr;
        logic [31:0]  len;
        logic [31:0]  flags;
    } comp_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_BLK_WAIT,
        ST_CLOSE_WAIT,
        ST_MERGE_RD,
        ST_MERGE_WAIT,
        ST_PUSH,
        ST_FIN_START,
        ST_FIN_WAIT,
        ST_FIN_RD,
        ST_FIN_PWAIT,
        ST_OUT
    } seq_state_t;

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
        rotr32 = (x >> n) | (x << (32 - n));
    endfunction

    // One G mix over four words.
    function automatic logic [127:0] gmix(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d,
                                          input logic [31:0] x, input logic [31:0] y);
        logic [31:0] ta;
        logic [31:0] tb;
        logic [31:0] tc;
        logic [31:0] td;
        ta = a + b + x;
        td = rotr32(d ^ ta, 16);
        tc = c + td;
        tb = rotr32(b ^ tc, 12);
        ta = ta + tb + y;
        td = rotr32(td ^ ta, 8);
        tc = tc + td;
        tb = rotr32(tb ^ tc, 7);
        gmix = {td, tc, tb, ta};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/b3sh_round.sv]
// ============================================================================
// b3sh_round
// Shared compression unit: one half round (four parallel G mixes) per cycle.
// ============================================================================
`default_nettype none

module b3sh_round
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire b3sh_pkg::comp_req_t req,
    output logic                     done,
    output logic [255:0]             cv_out
);
    import b3sh_pkg::*;

    logic [31:0] s_reg [16];
    logic [31:0] s_next [16];
    logic [31:0] m_reg [16];
    logic [31:0] m_next [16];
    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;

    // Sequence the fourteen half rounds
    always_comb
    begin
        logic [127:0] g0;
        logic [127:0] g1;
        logic [127:0] g2;
        logic [127:0] g3;
        s_next    = s_reg;
        m_next    = m_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        g0 = '0;
        g1 = '0;
        g2 = '0;
        g3 = '0;
        if (start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                s_next[i] = req.cv[32*i +: 32];
            end
            s_next[8]  = IV0;
            s_next[9]  = IV1;
            s_next[10] = IV2;
            s_next[11] = IV3;
            s_next[12] = req.ctr[31:0];
            s_next[13] = req.ctr[63:32];
            s_next[14] = req.len;
            s_next[15] = req.flags;
            for (int i = 0; i < 16; i++)
            begin
                m_next[i] = req.msg[32*i +: 32];
            end
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!step_reg[0])
            begin
                // Column step
                g0 = gmix(s_reg[0], s_reg[4], s_reg[8],  s_reg[12], m_reg[0], m_reg[1]);
                g1 = gmix(s_reg[1], s_reg[5], s_reg[9],  s_reg[13], m_reg[2], m_reg[3]);
                g2 = gmix(s_reg[2], s_reg[6], s_reg[10], s_reg[14], m_reg[4], m_reg[5]);
                g3 = gmix(s_reg[3], s_reg[7], s_reg[11], s_reg[15], m_reg[6], m_reg[7]);
                {s_next[12], s_next[8],  s_next[4], s_next[0]} = g0;
                {s_next[13], s_next[9],  s_next[5], s_next[1]} = g1;
                {s_next[14], s_next[10], s_next[6], s_next[2]} = g2;
                {s_next[15], s_next[11], s_next[7], s_next[3]} = g3;
            end
            else
            begin
                // Diagonal step, then permute the message
                g0 = gmix(s_reg[0], s_reg[5], s_reg[10], s_reg[15], m_reg[8],  m_reg[9]);
                g1 = gmix(s_reg[1], s_reg[6], s_reg[11], s_reg[12], m_reg[10], m_reg[11]);
                g2 = gmix(s_reg[2], s_reg[7], s_reg[8],  s_reg[13], m_reg[12], m_reg[13]);
                g3 = gmix(s_reg[3], s_reg[4], s_reg[9],  s_reg[14], m_reg[14], m_reg[15]);
                {s_next[15], s_next[10], s_next[5], s_next[0]} = g0;
                {s_next[12], s_next[11], s_next[6], s_next[1]} = g1;
                {s_next[13], s_next[8],  s_next[7], s_next[2]} = g2;
                {s_next[14], s_next[9],  s_next[4], s_next[3]} = g3;
                m_next[0]  = m_reg[2];
                m_next[1]  = m_reg[6];
                m_next[2]  = m_reg[3];
                m_next[3]  = m_reg[10];
                m_next[4]  = m_reg[7];
                m_next[5]  = m_reg[0];
                m_next[6]  = m_reg[4];
                m_next[7]  = m_reg[13];
                m_next[8]  = m_reg[1];
                m_next[9]  = m_reg[11];
                m_next[10] = m_reg[12];
                m_next[11] = m_reg[5];
                m_next[12] = m_reg[9];
                m_next[13] = m_reg[14];
                m_next[14] = m_reg[15];
                m_next[15] = m_reg[8];
            end
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(2 * ROUNDS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        m_reg <= m_next;
    end

    assign done = done_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cv_out[32*i +: 32] = s_reg[i] ^ s_reg[i + 8];
        end
    end

    // Done pulses exactly once, after the last half round
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finishing step");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for two cycles");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg != 4'd0 |-> !start)
        else $error("unit restarted mid compression");

endmodule

`default_nettype wire

[hw/rtl/b3sh_stack.sv]
// ============================================================================
// b3sh_stack
// Chaining value stack memory: one write and one registered read port.
// ============================================================================
`default_nettype none

module b3sh_stack
#(
    parameter int DEPTH = 54
)
(
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [255:0]              wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [255:0]                   rd_data
);
    logic [255:0] mem [DEPTH];

    // Write and read in clocked blocks
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/blake3_stream_hasher_core.sv]
// ============================================================================
// blake3_stream_hasher_core
// BLAKE3 256-bit hasher over a byte stream with a tree of chaining values.
// ============================================================================
// An input item is taken only while the core is idle; its bytes are then
// absorbed into the block buffer one at a time. A full 64-byte block goes into
// compression when a further byte meets it: the round unit is launched, runs
// fourteen half rounds and its result is collected. A chunk close compresses
// the last block, then merges one parent for each trailing zero of the new
// chunk count. A last item compresses the final block and one parent for each
// stack entry. The four digest words then leave in order through a single
// output register, one per cycle unless the receiver stalls. The input stays
// stalled until the fourth word is loaded. All compressions share one round
// unit that does half a round (four G mixes) per cycle.
// ============================================================================
`default_nettype none

module blake3_stream_hasher_core
#(
    parameter int STACK_DEPTH = 54
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] data_bytes,
    input  wire logic [3:0]  byte_count,
    input  wire logic        last_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_word,
    output logic             last_word,
    output logic             too_long
);
    import b3sh_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Configuration registers
    logic [1:0]   mode_reg;
    logic [255:0] key_reg;

    // Message state
    seq_state_t   state_reg, state_next;
    logic [255:0] cv_reg, cv_next;
    logic [511:0] buf_reg, buf_next;
    logic [6:0]   fill_reg, fill_next;
    logic [3:0]   blocks_reg, blocks_next;
    logic [53:0]  chunk_reg, chunk_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic         ovf_reg, ovf_next;
    logic [255:0] nv_reg, nv_next;
    logic [53:0]  total_reg, total_next;
    logic [63:0]  dat_reg, dat_next;
    logic [3:0]   left_reg, left_next;
    logic         last_reg, last_next;
    logic [1:0]   word_reg, word_next;
    logic         ovalid_reg, ovalid_next;
    logic [63:0]  oword_reg, oword_next;
    logic         olast_reg, olast_next;
    logic         otoo_reg, otoo_next;

    comp_req_t    req;
    logic         comp_start;
    logic         comp_done;
    logic [255:0] comp_out;

    logic         st_we;
    logic [AW-1:0] st_waddr;
    logic [AW-1:0] st_raddr;
    logic [255:0] st_rdata;

    logic [31:0]  mflags;
    logic [255:0] key_words;
    logic [255:0] chunk_cv;

    assign mflags    = (mode_reg == 2'd0) ? 32'd0 : (32'd8 << mode_reg);
    assign key_words = mode_reg[0] ? key_reg : IV_ALL;
    assign chunk_cv  = (blocks_reg == 4'd0) ? key_words : cv_reg;

    b3sh_round u_round
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (comp_start),
        .req    (req),
        .done   (comp_done),
        .cv_out (comp_out)
    );

    b3sh_stack #(.DEPTH(STACK_DEPTH)) u_stack
    (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (nv_reg),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            key_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE: mode_reg <= cfg_data[1:0];
                REG_KEY0: key_reg[63:0]    <= cfg_data;
                REG_KEY1: key_reg[127:64]  <= cfg_data;
                REG_KEY2: key_reg[191:128] <= cfg_data;
                REG_KEY3: key_reg[255:192] <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Sequencer: absorb bytes, compress blocks, merge the tree, finalize, send the digest
    always_comb
    begin
        logic [CW-1:0] cm1;
        state_next  = state_reg;
        cv_next     = cv_reg;
        buf_next    = buf_reg;
        fill_next   = fill_reg;
        blocks_next = blocks_reg;
        chunk_next  = chunk_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        nv_next     = nv_reg;
        total_next  = total_reg;
        dat_next    = dat_reg;
        left_next   = left_reg;
        last_next   = last_reg;
        word_next   = word_reg;
        ovalid_next = ovalid_reg;
        oword_next  = oword_reg;
        olast_next  = olast_reg;
        otoo_next   = otoo_reg;
        comp_start  = 1'b0;
        req.cv      = chunk_cv;
        req.msg     = buf_reg;
        req.ctr     = {10'd0, chunk_reg};
        req.len     = {25'd0, fill_reg};
        req.flags   = mflags | ((blocks_reg == 4'd0) ? FL_START : 32'd0);
        st_we       = 1'b0;
        cm1         = cnt_reg - CW'(1);
        st_waddr    = cnt_reg[AW-1:0];
        st_raddr    = cm1[AW-1:0];

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dat_next  = data_bytes;
                    left_next = (byte_count > 4'd8) ? 4'd8 : byte_count;
                    last_next = last_item;
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB:
            begin
                if (left_reg == 4'd0 || ovf_reg)
                begin
                    state_next = last_reg ? ST_FIN_START : ST_IDLE;
                end
                else if (fill_reg == 7'd64)
                begin
                    if (blocks_reg == 4'd15)
                    begin
                        if (chunk_reg == CHUNK_INDEX_MAX)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            req.flags  = mflags | FL_END;
                            comp_start = 1'b1;
                            state_next = ST_CLOSE_WAIT;
                        end
                    end
                    else
                    begin
                        req.len    = 32'd64;
                        comp_start = 1'b1;
                        state_next = ST_BLK_WAIT;
                    end
                end
                else
                begin
                    buf_next[8*fill_reg[5:0] +: 8] = dat_reg[7:0];
                    dat_next  = dat_reg >> 8;
                    fill_next = fill_reg + 7'd1;
                    left_next = left_reg - 4'd1;
                end
            end
            ST_BLK_WAIT:
            begin
                if (comp_done)
                begin
                    cv_next     = comp_out;
                    blocks_next = blocks_reg + 4'd1;
                    fill_next   = '0;
                    buf_next    = '0;
                    state_next  = ST_ABSORB;
                end
            end
            ST_CLOSE_WAIT:
            begin
                if (comp_done)
                begin
                    nv_next    = comp_out;
                    total_next = chunk_reg + 54'd1;
                    state_next = ST_MERGE_RD;
                end
            end
            ST_MERGE_RD:
            begin
                // Pop a left sibling for each trailing zero of the count
                if (total_reg[0])
                begin
                    state_next = ST_PUSH;
                end
                else if (cnt_reg == '0)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_ABSORB;
                end
                else
                begin
                    cnt_next   = cm1;
                    state_next = ST_MERGE_WAIT;
                end
            end
            ST_MERGE_WAIT:
            begin
                req.cv    = key_words;
                req.msg   = {nv_reg, st_rdata};
                req.ctr   = '0;
                req.len   = 32'd64;
                req.flags = mflags | FL_PARENT;
                if (word_reg == 2'd0)
                begin
                    comp_start = 1'b1;
                    word_next  = 2'd1;
                end
                else if (comp_done)
                begin
                    nv_next    = comp_out;
                    total_next = total_reg >> 1;
                    word_next  = 2'd0;
                    state_next = ST_MERGE_RD;
                end
            end
            ST_PUSH:
            begin
                if (cnt_reg >= CW'(STACK_DEPTH))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    st_we       = 1'b1;
                    cnt_next    = cnt_reg + CW'(1);
                    chunk_next  = chunk_reg + 54'd1;
                    blocks_next = '0;
                    fill_next   = '0;
                    buf_next    = '0;
                end
                state_next = ST_ABSORB;
            end
            ST_FIN_START:
            begin
                if (ovf_reg)
                begin
                    nv_next    = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    req.flags  = mflags | ((blocks_reg == 4'd0) ? FL_START : 32'd0) | FL_END
                               | ((cnt_reg == '0) ? FL_ROOT : 32'd0);
                    comp_start = 1'b1;
                    state_next = ST_FIN_WAIT;
                end
            end
            ST_FIN_WAIT:
            begin
                if (comp_done)
                begin
                    nv_next    = comp_out;
                    state_next = ST_FIN_RD;
                end
            end
            ST_FIN_RD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_FIN_PWAIT;
                    word_next  = 2'd0;
                end
            end
            ST_FIN_PWAIT:
            begin
                // Stack read address is count minus one; data valid now
                req.cv    = key_words;
                req.msg   = {nv_reg, st_rdata};
                req.ctr   = '0;
                req.len   = 32'd64;
                req.flags = mflags | FL_PARENT | ((cnt_reg == CW'(1)) ? FL_ROOT : 32'd0);
                if (word_reg == 2'd0)
                begin
                    comp_start = 1'b1;
                    word_next  = 2'd1;
                end
                else if (comp_done)
                begin
                    nv_next    = comp_out;
                    cnt_next   = cm1;
                    word_next  = 2'd0;
                    state_next = ST_FIN_RD;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = nv_reg[64*word_reg +: 64];
                    olast_next  = (word_reg == 2'd3);
                    otoo_next   = ovf_reg;
                    word_next   = word_reg + 2'd1;
                    if (word_reg == 2'd3)
                    begin
                        cv_next     = IV_ALL;
                        buf_next    = '0;
                        fill_next   = '0;
                        blocks_next = '0;
                        chunk_next  = '0;
                        cnt_next    = '0;
                        ovf_next    = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cv_reg     <= IV_ALL;
            buf_reg    <= '0;
            fill_reg   <= '0;
            blocks_reg <= '0;
            chunk_reg  <= '0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            word_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cv_reg     <= cv_next;
            buf_reg    <= buf_next;
            fill_reg   <= fill_next;
            blocks_reg <= blocks_next;
            chunk_reg  <= chunk_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            word_reg   <= word_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        nv_reg    <= nv_next;
        total_reg <= total_next;
        dat_reg   <= dat_next;
        left_reg  <= left_next;
        last_reg  <= last_next;
        oword_reg <= oword_next;
        olast_reg <= olast_next;
        otoo_reg  <= otoo_next;
    end

    assign out_valid   = ovalid_reg;
    assign digest_word = oword_reg;
    assign last_word   = olast_reg;
    assign too_long    = otoo_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 7'd64)
        else $error("block fill past 64");
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count past depth");
    a_out_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("digest word outside output phase");

endmodule

`default_nettype wire
